// ===== rtl/i2c_master_bit_engine_top_assert.svh =====
// ---------------------------------------------------------------------------
// i2c master bit engine assertion macros
// concurrent assertion shorthands used by the port checker
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2CMBE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c master bit engine check failed");

// next-cycle implication, disabled during reset
`define I2CMBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c master bit engine check failed");

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// ---------------------------------------------------------------------------
// i2c master bit engine package
// item types, command and status codes, phase encoding
// ---------------------------------------------------------------------------
package i2cmbe_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

  // reset values of the timing registers
  localparam logic [15:0] BIT_DELAY_RST = 16'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

  // command codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // write status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RESP = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  // top bit of the shift register
  localparam logic [7:0] MSB_MASK = 8'h80;

  // last bit index of a byte
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_S_REL, PH_S_SDA, PH_S_SCL,
    PH_P_SDA, PH_P_REL, PH_P_SCL,
    PH_W_HI, PH_W_LO, PH_W_ACK1, PH_W_ACK2, PH_W_ACKLO, PH_W_BUSY,
    PH_R_HI, PH_R_LO, PH_R_AHI, PH_R_ALO
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_in;
    logic       ack_out;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       idle;
    logic       done_res;
    logic [7:0] read_byte;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_bit_engine_top.sv =====
// the result item of an accepted tick item is loaded into the output register when the item is accepted
// throughput: one tick item per clock cycle while results are taken; the output register drains while it refills
// the only stall is a held result that the receiver is not taking (in_stall = out_valid & out_stall)
// reset (rst_n low, synchronous): phase idle, both lines released, status ok,
//   read byte zero, bit delay 10 and timeout 1000 ticks, output register empty
// ---------------------------------------------------------------------------
// i2c master bit engine top
// tick-driven i2c master: start, stop, byte write with ack check, byte read
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  i2cmbe_pkg::in_item_t                in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2cmbe_pkg::out_item_t               out_item,
  input  logic                                cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // timing registers
  logic [15:0] bit_delay_r;
  logic [15:0] timeout_r;

  // engine state
  i2cmbe_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_hold_r, ack_hold_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  read_r, read_nxt;

  // output register
  logic                  out_valid_r;
  i2cmbe_pkg::out_item_t out_item_r, out_item_nxt;

  logic        in_fire;
  logic        is_idle;
  logic        tick_end;
  logic        done;
  logic [15:0] wait_len;
  logic [7:0]  shift_sh;

  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign is_idle   = (phase_r == i2cmbe_pkg::PH_IDLE);
  // the current wait runs out on this tick
  assign tick_end  = in_fire & ~is_idle & (wait_r == 16'd1);
  assign done      = tick_end & (phase_nxt == i2cmbe_pkg::PH_IDLE);
  assign shift_sh  = {shift_r[6:0], 1'b0};
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire && is_idle) begin
      unique case (in_item.op)
        i2cmbe_pkg::OP_START: phase_nxt = i2cmbe_pkg::PH_S_REL;
        i2cmbe_pkg::OP_STOP:  phase_nxt = i2cmbe_pkg::PH_P_SDA;
        i2cmbe_pkg::OP_WRITE: phase_nxt = i2cmbe_pkg::PH_W_HI;
        i2cmbe_pkg::OP_READ:  phase_nxt = i2cmbe_pkg::PH_R_HI;
        default:              phase_nxt = i2cmbe_pkg::PH_IDLE;
      endcase
    end else if (tick_end) begin
      unique case (phase_r)
        i2cmbe_pkg::PH_S_REL: phase_nxt = i2cmbe_pkg::PH_S_SDA;
        i2cmbe_pkg::PH_S_SDA: phase_nxt = i2cmbe_pkg::PH_S_SCL;
        i2cmbe_pkg::PH_P_SDA: phase_nxt = i2cmbe_pkg::PH_P_REL;
        i2cmbe_pkg::PH_P_REL: phase_nxt = i2cmbe_pkg::PH_P_SCL;
        i2cmbe_pkg::PH_W_HI:  phase_nxt = i2cmbe_pkg::PH_W_LO;
        i2cmbe_pkg::PH_W_LO:
          phase_nxt = (bit_count_r == i2cmbe_pkg::LAST_BIT) ? i2cmbe_pkg::PH_W_ACK1
                                                            : i2cmbe_pkg::PH_W_HI;
        i2cmbe_pkg::PH_W_ACK1:
          phase_nxt = in_item.sda_in ? i2cmbe_pkg::PH_W_ACK2 : i2cmbe_pkg::PH_W_ACKLO;
        i2cmbe_pkg::PH_W_ACK2:
          phase_nxt = in_item.sda_in ? i2cmbe_pkg::PH_IDLE : i2cmbe_pkg::PH_W_ACKLO;
        i2cmbe_pkg::PH_W_ACKLO:
          phase_nxt = in_item.sda_in ? i2cmbe_pkg::PH_IDLE : i2cmbe_pkg::PH_W_BUSY;
        i2cmbe_pkg::PH_R_HI:  phase_nxt = i2cmbe_pkg::PH_R_LO;
        i2cmbe_pkg::PH_R_LO:
          phase_nxt = (bit_count_r == i2cmbe_pkg::LAST_BIT) ? i2cmbe_pkg::PH_R_AHI
                                                            : i2cmbe_pkg::PH_R_HI;
        i2cmbe_pkg::PH_R_AHI: phase_nxt = i2cmbe_pkg::PH_R_ALO;
        default:              phase_nxt = i2cmbe_pkg::PH_IDLE;
      endcase
    end
  end

  // wait length for the phase being entered, zero acts as one tick
  always_comb begin
    if (phase_nxt == i2cmbe_pkg::PH_W_ACK2 || phase_nxt == i2cmbe_pkg::PH_W_BUSY) begin
      wait_len = timeout_r;
    end else begin
      wait_len = bit_delay_r;
    end
    if (wait_len == 16'd0) begin
      wait_len = 16'd1;
    end
  end

  // line drives, shifter, counters and results
  always_comb begin
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_hold_nxt  = ack_hold_r;
    status_nxt    = status_r;
    read_nxt      = read_r;
    wait_nxt      = wait_r;

    if (in_fire && is_idle) begin
      case (in_item.op)
        i2cmbe_pkg::OP_START: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2cmbe_pkg::OP_STOP: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        i2cmbe_pkg::OP_WRITE: begin
          bit_count_nxt = 3'd0;
          shift_nxt     = in_item.byte_in;
          sda_nxt       = |(in_item.byte_in & i2cmbe_pkg::MSB_MASK);
          scl_nxt       = 1'b1;
        end
        i2cmbe_pkg::OP_READ: begin
          bit_count_nxt = 3'd0;
          shift_nxt     = 8'd0;
          ack_hold_nxt  = in_item.ack_out;
          sda_nxt       = 1'b1;
          scl_nxt       = 1'b1;
        end
        default: ;
      endcase
    end else if (tick_end) begin
      case (phase_r)
        i2cmbe_pkg::PH_S_REL: sda_nxt = 1'b0;
        i2cmbe_pkg::PH_S_SDA: scl_nxt = 1'b0;
        i2cmbe_pkg::PH_P_SDA: sda_nxt = 1'b1;
        i2cmbe_pkg::PH_P_REL: scl_nxt = 1'b0;
        i2cmbe_pkg::PH_W_HI:  scl_nxt = 1'b0;
        i2cmbe_pkg::PH_W_LO: begin
          shift_nxt = shift_sh;
          scl_nxt   = 1'b1;
          if (bit_count_r == i2cmbe_pkg::LAST_BIT) begin
            sda_nxt = 1'b1;
          end else begin
            bit_count_nxt = bit_count_r + 3'd1;
            sda_nxt       = |(shift_sh & i2cmbe_pkg::MSB_MASK);
          end
        end
        i2cmbe_pkg::PH_W_ACK1, i2cmbe_pkg::PH_W_ACK2: begin
          if (!in_item.sda_in) begin
            scl_nxt = 1'b0;
          end else if (phase_r == i2cmbe_pkg::PH_W_ACK2) begin
            status_nxt = i2cmbe_pkg::ST_NO_RESP;
          end
        end
        i2cmbe_pkg::PH_W_ACKLO: begin
          if (in_item.sda_in) begin
            status_nxt = i2cmbe_pkg::ST_OK;
          end
        end
        i2cmbe_pkg::PH_W_BUSY:
          status_nxt = in_item.sda_in ? i2cmbe_pkg::ST_OK : i2cmbe_pkg::ST_BUSY;
        i2cmbe_pkg::PH_R_HI: begin
          shift_nxt = {shift_r[6:0], in_item.sda_in};
          scl_nxt   = 1'b0;
        end
        i2cmbe_pkg::PH_R_LO: begin
          scl_nxt = 1'b1;
          if (bit_count_r == i2cmbe_pkg::LAST_BIT) begin
            sda_nxt = ~ack_hold_r;
          end else begin
            bit_count_nxt = bit_count_r + 3'd1;
          end
        end
        i2cmbe_pkg::PH_R_AHI: scl_nxt = 1'b0;
        i2cmbe_pkg::PH_R_ALO: read_nxt = shift_r;
        default: ;
      endcase
    end

    // wait counter: clear on return to idle, reload on every step, count down otherwise
    if (in_fire) begin
      if (phase_nxt == i2cmbe_pkg::PH_IDLE) begin
        wait_nxt = 16'd0;
      end else if ((is_idle && phase_nxt != i2cmbe_pkg::PH_IDLE) || tick_end) begin
        wait_nxt = wait_len;
      end else begin
        wait_nxt = wait_r - 16'd1;
      end
    end
  end

  // result item for this tick
  always_comb begin
    out_item_nxt.scl_out   = scl_nxt;
    out_item_nxt.sda_out   = sda_nxt;
    out_item_nxt.idle      = (phase_nxt == i2cmbe_pkg::PH_IDLE);
    out_item_nxt.done_res  = done;
    out_item_nxt.read_byte = read_nxt;
    out_item_nxt.status    = status_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r <= i2cmbe_pkg::BIT_DELAY_RST;
      timeout_r   <= i2cmbe_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == i2cmbe_pkg::CFG_BIT_DELAY) begin
        bit_delay_r <= cfg_data;
      end else if (cfg_index == i2cmbe_pkg::CFG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cmbe_pkg::PH_IDLE;
      bit_count_r <= 3'd0;
      shift_r     <= 8'd0;
      wait_r      <= 16'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_hold_r  <= 1'b0;
      status_r    <= i2cmbe_pkg::ST_OK;
      read_r      <= 8'd0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      wait_r      <= wait_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_hold_r  <= ack_hold_nxt;
      status_r    <= status_nxt;
      read_r      <= read_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== rtl/i2cmbe_checker.sv =====
// ---------------------------------------------------------------------------
// i2c master bit engine port checker
// watches the top level ports for handshake and result consistency
// ---------------------------------------------------------------------------
`include "i2c_master_bit_engine_top_assert.svh"

module i2cmbe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input i2cmbe_pkg::out_item_t out_item
);

  // a held result stays put
  `I2CMBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // input is only held back by a stalled result
  `I2CMBE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // every accepted tick item yields a result item
  `I2CMBE_ASSERT_NEXT(a_item_result, in_valid && !in_stall, out_valid)

  // a finished command leaves the engine idle
  `I2CMBE_ASSERT_NOW(a_done_idle, out_valid && out_item.done_res, out_item.idle)

  // status never takes the unused code
  `I2CMBE_ASSERT_NOW(a_status_code, out_valid, out_item.status != i2cmbe_pkg::ST_BUSY + 2'd1)

endmodule

bind i2c_master_bit_engine_top i2cmbe_checker u_i2cmbe_checker (.*);
